// ===== sv/ica_pkg.sv =====
// ----------------------------------------------------------------------------
// ica_pkg
// Shared widths, operation codes and status codes of the interval channel
// allocator.
// ----------------------------------------------------------------------------
package ica_pkg;

  localparam int TABLE_SLOTS      = 16;
  localparam int SLOT_W           = $clog2(TABLE_SLOTS);
  localparam int CHANNELS         = 6;
  localparam int DATA_CHANNEL_IDS = 16;
  localparam int DCNT_W           = $clog2(DATA_CHANNEL_IDS + 1);

  localparam int OP_W    = 2;
  localparam int TIME_W  = 32;
  localparam int DCH_W   = 4;
  localparam int CH_W    = 3;
  localparam int CH_IDS  = 1 << CH_W;
  localparam int RSLOT_W = 4;
  localparam int EXCL_W  = 16;
  localparam int STAT_W  = 3;
  localparam int OSLOT_W = 4;

  typedef enum logic [OP_W-1:0] {
    OP_VALIDATE = 2'd0,
    OP_APPEND   = 2'd1,
    OP_REMOVE   = 2'd2,
    OP_NOP      = 2'd3
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK             = 3'd0,
    ST_DATA_EXHAUSTED = 3'd1,
    ST_NO_CHANNEL     = 3'd2,
    ST_FULL           = 3'd3,
    ST_SLOT_EMPTY     = 3'd4
  } status_t;

  // One stored segment, one memory word.
  typedef struct packed {
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic [DCH_W-1:0]  data_channel;
    logic [CH_W-1:0]   channel;
  } segment_t;

endpackage

// ===== sv/ica_req_if.sv =====
// ----------------------------------------------------------------------------
// ica_req_if
// Request channel: one operation item with its segment and mask fields.
// ----------------------------------------------------------------------------
interface ica_req_if;
  logic                             valid;
  logic                             ready;
  logic [ica_pkg::OP_W-1:0]         operation;
  logic [ica_pkg::TIME_W-1:0]       start_time;
  logic [ica_pkg::TIME_W-1:0]       end_time;
  logic [ica_pkg::DCH_W-1:0]        data_channel;
  logic [ica_pkg::CH_W-1:0]         channel;
  logic [ica_pkg::RSLOT_W-1:0]      remove_slot;
  logic [ica_pkg::EXCL_W-1:0]       exclude_mask;

  modport source (
    output valid, operation, start_time, end_time, data_channel, channel,
           remove_slot, exclude_mask,
    input  ready
  );
  modport sink (
    input  valid, operation, start_time, end_time, data_channel, channel,
           remove_slot, exclude_mask,
    output ready
  );
endinterface

// ===== sv/ica_rsp_if.sv =====
// ----------------------------------------------------------------------------
// ica_rsp_if
// Result channel: one status item per request.
// ----------------------------------------------------------------------------
interface ica_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [ica_pkg::STAT_W-1:0]   status;
  logic [ica_pkg::CH_W-1:0]     assigned_channel;
  logic [ica_pkg::OSLOT_W-1:0]  slot;
  logic                         table_empty;

  modport source (
    output valid, status, assigned_channel, slot, table_empty,
    input  ready
  );
  modport sink (
    input  valid, status, assigned_channel, slot, table_empty,
    output ready
  );
endinterface

// ===== sv/interval_channel_allocator.sv =====
// ----------------------------------------------------------------------------
// interval_channel_allocator
// Segment table with overlap check and lowest-free real channel selection.
// ----------------------------------------------------------------------------
// Sequence: validate runs from accept to result as one memory read per
//   slot in ST_SCAN, the read data of the final slot in ST_LAST, then the
//   channel pick and the result register load in ST_DONE. Append, remove
//   and no-op go from accept straight to ST_DONE.
// Throughput: one item at a time; validate sweeps every slot over the
//   single read port of the segment memory.
// Reset: rst clears every slot valid bit and the control state; segment
//   memory contents stay undefined and are only read under a valid bit.
module interval_channel_allocator (
  input  logic          clk,
  input  logic          rst,
  ica_req_if.sink       req,
  ica_rsp_if.source     rsp
);

  localparam int Slots   = ica_pkg::TABLE_SLOTS;
  localparam int SlotW   = ica_pkg::SLOT_W;
  localparam int Chans   = ica_pkg::CHANNELS;
  localparam int DchIds  = ica_pkg::DATA_CHANNEL_IDS;
  localparam int DcntW   = ica_pkg::DCNT_W;
  localparam int ChW     = ica_pkg::CH_W;
  localparam int ChIds   = ica_pkg::CH_IDS;
  localparam int OslotW  = ica_pkg::OSLOT_W;

  // One-hot control states.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,  // take a request item
    ST_SCAN = 4'b0010,  // issue one slot read per cycle
    ST_LAST = 4'b0100,  // absorb the read data of the final slot
    ST_DONE = 4'b1000   // commit the operation and load the result register
  } state_t;

  state_t state, state_next;

  // Held request.
  ica_pkg::op_t                cur_op;
  logic [ica_pkg::TIME_W-1:0]  cur_tstart;
  logic [ica_pkg::TIME_W-1:0]  cur_end;
  logic [ica_pkg::DCH_W-1:0]   cur_dch;
  logic [ChW-1:0]              cur_ch;
  logic [ica_pkg::RSLOT_W-1:0] cur_rslot;
  logic [ica_pkg::EXCL_W-1:0]  cur_excl;

  // Table: valid bits in flops, segment fields in a synchronous memory.
  logic [Slots-1:0]       slot_valid, slot_valid_next;
  ica_pkg::segment_t      seg_mem [Slots];
  ica_pkg::segment_t      rd_data;
  ica_pkg::segment_t      wr_data;
  logic                   mem_we;

  // Sweep pipeline: scan_idx is the read address, chk_idx the slot whose
  // data sits in rd_data when chk_vld is high.
  logic [SlotW-1:0]       scan_idx;
  logic [SlotW-1:0]       chk_idx;
  logic                   chk_vld;
  logic                   hit;

  // Accumulated usage over the overlapping segments.
  logic [DchIds-1:0]      data_used;
  logic [DcntW-1:0]       data_cnt;
  logic [ChIds-1:0]       real_used;

  // Result register.
  logic                   out_valid;
  ica_pkg::status_t       out_status;
  logic [ChW-1:0]         out_assigned;
  logic [OslotW-1:0]      out_slot;
  logic                   out_empty;
  logic                   out_free;

  logic                   accept;
  logic                   commit;

  ica_pkg::status_t       status_next;
  logic [ChW-1:0]         assigned_next;
  logic [OslotW-1:0]      slot_next;

  logic [SlotW-1:0]       free_idx;
  logic                   free_found;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign out_free  = !out_valid || rsp.ready;
  assign commit    = (state == ST_DONE) && out_free;

  assign rsp.valid            = out_valid;
  assign rsp.status           = out_status;
  assign rsp.assigned_channel = out_assigned;
  assign rsp.slot             = out_slot;
  assign rsp.table_empty      = out_empty;

  // Hold the request for the whole operation.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_op     <= ica_pkg::op_t'(req.operation);
      cur_tstart <= req.start_time;
      cur_end    <= req.end_time;
      cur_dch    <= req.data_channel;
      cur_ch     <= req.channel;
      cur_rslot  <= req.remove_slot;
      cur_excl   <= req.exclude_mask;
    end
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (ica_pkg::op_t'(req.operation) == ica_pkg::OP_VALIDATE) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (scan_idx == SlotW'(Slots - 1)) begin
          state_next = ST_LAST;
        end
      end
      ST_LAST: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      chk_vld <= 1'b0;
    end else begin
      state   <= state_next;
      chk_vld <= (state == ST_SCAN);
    end
  end

  // Advance the read address through every slot once per validate.
  always_ff @(posedge clk) begin
    if (accept) begin
      scan_idx <= '0;
    end else if (state == ST_SCAN) begin
      scan_idx <= scan_idx + SlotW'(1);
    end
    chk_idx <= scan_idx;
  end

  // Segment memory: one write port (append), one registered read port
  // (sweep). Appends commit only in ST_DONE, so a write never meets a read
  // of the same sweep.
  assign wr_data.start_time   = cur_tstart;
  assign wr_data.end_time     = cur_end;
  assign wr_data.data_channel = cur_dch;
  assign wr_data.channel      = cur_ch;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      seg_mem[free_idx] <= wr_data;
    end
    rd_data <= seg_mem[scan_idx];
  end

  // Closed-interval overlap against the slot just read, in the four-way
  // form that also covers reversed intervals without reordering them.
  always_comb begin
    logic ov;
    ov = (cur_tstart >= rd_data.start_time && cur_tstart <= rd_data.end_time) ||
         (cur_end <= rd_data.end_time && cur_end >= rd_data.start_time) ||
         (rd_data.start_time >= cur_tstart && rd_data.start_time <= cur_end) ||
         (rd_data.end_time <= cur_end && rd_data.end_time >= cur_tstart);
    hit = chk_vld && slot_valid[chk_idx] && !cur_excl[chk_idx] && ov;
  end

  // Collect data and real channel usage; count each new data channel once.
  always_ff @(posedge clk) begin
    if (rst || accept) begin
      data_used <= '0;
      real_used <= '0;
      data_cnt  <= '0;
    end else if (hit) begin
      data_used[rd_data.data_channel] <= 1'b1;
      real_used[rd_data.channel]      <= 1'b1;
      if (!data_used[rd_data.data_channel]) begin
        data_cnt <= data_cnt + DcntW'(1);
      end
    end
  end

  // Lowest free slot for append.
  always_comb begin
    free_idx   = '0;
    free_found = 1'b0;
    for (int i = Slots - 1; i >= 0; i--) begin
      if (!slot_valid[i]) begin
        free_idx   = SlotW'(i);
        free_found = 1'b1;
      end
    end
  end

  // Operation outcome and table update.
  always_comb begin
    status_next     = ica_pkg::ST_OK;
    assigned_next   = '0;
    slot_next       = '0;
    slot_valid_next = slot_valid;
    mem_we          = 1'b0;
    case (cur_op)
      ica_pkg::OP_VALIDATE: begin
        if (data_cnt >= DcntW'(Chans)) begin
          status_next = ica_pkg::ST_DATA_EXHAUSTED;
        end else begin
          status_next = ica_pkg::ST_NO_CHANNEL;
          for (int i = Chans; i >= 1; i--) begin
            if (!real_used[i]) begin
              status_next   = ica_pkg::ST_OK;
              assigned_next = ChW'(i);
            end
          end
        end
      end
      ica_pkg::OP_APPEND: begin
        if (free_found) begin
          slot_next                 = OslotW'(free_idx);
          slot_valid_next[free_idx] = 1'b1;
          mem_we                    = commit;
        end else begin
          status_next = ica_pkg::ST_FULL;
        end
      end
      ica_pkg::OP_REMOVE: begin
        if (slot_valid[cur_rslot]) begin
          slot_valid_next[cur_rslot] = 1'b0;
        end else begin
          status_next = ica_pkg::ST_SLOT_EMPTY;
        end
      end
      default: begin
        status_next = ica_pkg::ST_OK;
      end
    endcase
  end

  // Commit the table update and load the result; drop the result once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (commit) begin
        slot_valid <= slot_valid_next;
        out_valid  <= 1'b1;
      end else if (rsp.ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_status   <= status_next;
      out_assigned <= assigned_next;
      out_slot     <= slot_next;
      out_empty    <= (slot_valid_next == '0);
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_result_from_commit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result appeared without a commit");

  a_count_matches_mask: assert property (@(posedge clk) disable iff (rst)
    data_cnt == DcntW'($countones(data_used)))
    else $error("data channel count out of step with usage mask");

  a_no_write_in_sweep: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> !(state == ST_SCAN || state == ST_LAST || chk_vld))
    else $error("segment write during slot sweep");

  a_append_sets_valid: assert property (@(posedge clk) disable iff (rst)
    mem_we |=> slot_valid[$past(free_idx)])
    else $error("appended slot not marked valid");

  a_hit_only_on_valid: assert property (@(posedge clk) disable iff (rst)
    hit |-> (state == ST_SCAN || state == ST_LAST))
    else $error("overlap hit outside the sweep");

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the interval channel allocator. Requests go in
// over the valid/ready request channel while a local model of the segment
// table predicts each status item. Every item coming back is compared field
// by field with the oldest prediction. Directed items cover the table edges.
// Random items follow, with varying table fill, random idle cycles on both
// sides, a long result hold-off and a full drain pause.
// ----------------------------------------------------------------------------
module tb;

  localparam int TABLE_SLOTS  = ica_pkg::TABLE_SLOTS;
  localparam int CHANNELS     = ica_pkg::CHANNELS;
  localparam int TIME_W       = ica_pkg::TIME_W;
  localparam int DCH_W        = ica_pkg::DCH_W;
  localparam int CH_W         = ica_pkg::CH_W;
  localparam int CH_IDS       = ica_pkg::CH_IDS;
  localparam int RSLOT_W      = ica_pkg::RSLOT_W;
  localparam int EXCL_W       = ica_pkg::EXCL_W;
  localparam int OSLOT_W      = ica_pkg::OSLOT_W;

  localparam int IDLE_PCT     = 19;      // idle cycles per hundred, each side
  localparam int CYCLE_LIMIT  = 400000;  // watchdog, well above a slow run
  localparam int DRAIN_CYCLES = 2 * (TABLE_SLOTS + 3) + 8;
  localparam int SHOW_LIMIT   = 10;      // mismatches printed in full

  typedef struct packed {
    ica_pkg::op_t         operation;
    logic [TIME_W-1:0]    start_time;
    logic [TIME_W-1:0]    end_time;
    logic [DCH_W-1:0]     data_channel;
    logic [CH_W-1:0]      channel;
    logic [RSLOT_W-1:0]   remove_slot;
    logic [EXCL_W-1:0]    exclude_mask;
  } alloc_req_t;

  typedef struct packed {
    ica_pkg::status_t     status;
    logic [CH_W-1:0]      assigned_channel;
    logic [OSLOT_W-1:0]   slot;
    logic                 table_empty;
  } alloc_result_t;

  logic clk;
  logic rst;

  ica_req_if req ();
  ica_rsp_if rsp ();

  interval_channel_allocator u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Local copy of the segment table, advanced once per accepted request.
  logic [TABLE_SLOTS-1:0] tbl_valid;
  logic [TIME_W-1:0]      tbl_start [TABLE_SLOTS];
  logic [TIME_W-1:0]      tbl_end   [TABLE_SLOTS];
  logic [DCH_W-1:0]       tbl_dch   [TABLE_SLOTS];
  logic [CH_W-1:0]        tbl_ch    [TABLE_SLOTS];

  alloc_result_t alloc_expect_q [$];

  // Shared between the test tasks and the result side.
  bit steady_flow;       // no idle cycles on either side while set
  int hold_request;      // result hold-off asked by a test, in cycles
  int holdoff_left;      // owned by the result side

  int mismatch_count;
  int results_seen;
  int op_seen     [4];
  int status_seen [5];
  int cycle_count;

  // --------------------------------------------------------------------------
  // Clock and watchdog
  // --------------------------------------------------------------------------
  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("watchdog expired after %0d cycles, %0d results pending",
               cycle_count, alloc_expect_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Table model
  // --------------------------------------------------------------------------
  // Closed-interval overlap. A reversed interval is taken as given: the same
  // four endpoint tests apply, nothing is swapped.
  function automatic bit spans_overlap(input logic [TIME_W-1:0] s,
                                       input logic [TIME_W-1:0] e,
                                       input logic [TIME_W-1:0] cs,
                                       input logic [TIME_W-1:0] ce);
    return (s >= cs && s <= ce) || (e >= cs && e <= ce) ||
           (cs >= s && cs <= e) || (ce >= s && ce <= e);
  endfunction

  // Work out the status item for one request and update the table copy.
  function automatic alloc_result_t predict_alloc(input alloc_req_t it);
    alloc_result_t          res;
    logic [15:0]            dch_used;
    logic [CH_IDS-1:0]      ch_used;
    int                     dch_count;
    bit                     placed;
    res      = '0;
    dch_used = '0;
    ch_used  = '0;
    placed   = 1'b0;
    res.status = ica_pkg::ST_OK;
    case (it.operation)
      ica_pkg::OP_VALIDATE: begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          // slots past the mask width are never excluded
          if (tbl_valid[i] && !(i < EXCL_W && it.exclude_mask[i]) &&
              spans_overlap(it.start_time, it.end_time, tbl_start[i], tbl_end[i])) begin
            dch_used[tbl_dch[i]] = 1'b1;
            ch_used[tbl_ch[i]]   = 1'b1;
          end
        end
        dch_count = $countones(dch_used);
        if (dch_count >= CHANNELS) begin
          res.status = ica_pkg::ST_DATA_EXHAUSTED;
        end else begin
          res.status = ica_pkg::ST_NO_CHANNEL;
          for (int c = 1; c <= CHANNELS; c++) begin
            if (!placed && !ch_used[c]) begin
              placed               = 1'b1;
              res.status           = ica_pkg::ST_OK;
              res.assigned_channel = CH_W'(c);
            end
          end
        end
      end
      ica_pkg::OP_APPEND: begin
        res.status = ica_pkg::ST_FULL;
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (!placed && !tbl_valid[i]) begin
            placed       = 1'b1;
            tbl_valid[i] = 1'b1;
            tbl_start[i] = it.start_time;
            tbl_end[i]   = it.end_time;
            tbl_dch[i]   = it.data_channel;
            tbl_ch[i]    = it.channel;
            res.status   = ica_pkg::ST_OK;
            res.slot     = OSLOT_W'(i);
          end
        end
      end
      ica_pkg::OP_REMOVE: begin
        if (int'(it.remove_slot) < TABLE_SLOTS && tbl_valid[it.remove_slot])
          tbl_valid[it.remove_slot] = 1'b0;
        else
          res.status = ica_pkg::ST_SLOT_EMPTY;
      end
      default: ;
    endcase
    res.table_empty = (tbl_valid == '0);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  // Offer one item, idling first at random; the prediction is queued at the
  // edge where the block takes the item. Valid is left high on return so
  // back-to-back items need no second assignment in one step.
  task automatic send_request(input alloc_req_t it);
    while (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.operation    <= it.operation;
    req.start_time   <= it.start_time;
    req.end_time     <= it.end_time;
    req.data_channel <= it.data_channel;
    req.channel      <= it.channel;
    req.remove_slot  <= it.remove_slot;
    req.exclude_mask <= it.exclude_mask;
    do @(posedge clk); while (req.ready !== 1'b1);
    alloc_expect_q.insert(alloc_expect_q.size(), predict_alloc(it));
    op_seen[it.operation]++;
  endtask

  function automatic alloc_req_t mk_validate(input logic [TIME_W-1:0] s,
                                             input logic [TIME_W-1:0] e,
                                             input logic [EXCL_W-1:0] mask);
    alloc_req_t it;
    it              = '0;
    it.operation    = ica_pkg::OP_VALIDATE;
    it.start_time   = s;
    it.end_time     = e;
    it.exclude_mask = mask;
    return it;
  endfunction

  function automatic alloc_req_t mk_append(input logic [TIME_W-1:0] s,
                                           input logic [TIME_W-1:0] e,
                                           input logic [DCH_W-1:0]  dch,
                                           input logic [CH_W-1:0]   ch);
    alloc_req_t it;
    it              = '0;
    it.operation    = ica_pkg::OP_APPEND;
    it.start_time   = s;
    it.end_time     = e;
    it.data_channel = dch;
    it.channel      = ch;
    return it;
  endfunction

  function automatic alloc_req_t mk_remove(input logic [RSLOT_W-1:0] idx);
    alloc_req_t it;
    it             = '0;
    it.operation   = ica_pkg::OP_REMOVE;
    it.remove_slot = idx;
    return it;
  endfunction

  // Tick values cluster in a narrow window so segments overlap often, with
  // the extremes and full-range values mixed in.
  function automatic logic [TIME_W-1:0] pick_tick();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      2, 3:    return $urandom();
      default: return $urandom_range(400);
    endcase
  endfunction

  // One random request. Fields that the operation ignores carry noise. The
  // operation mix steers the table fill toward fill_target.
  function automatic alloc_req_t pick_request(input int fill_target);
    alloc_req_t it;
    int         used;
    int         roll;
    int         live [$];
    it.start_time   = pick_tick();
    case ($urandom_range(9))
      0:       it.end_time = pick_tick();   // may land before the start
      1:       it.end_time = '1;
      default: it.end_time = it.start_time + $urandom_range(80);
    endcase
    it.data_channel = $urandom_range(1) ? DCH_W'($urandom_range(15))
                                        : DCH_W'($urandom_range(4));
    it.channel      = CH_W'($urandom_range(7));
    it.remove_slot  = RSLOT_W'($urandom_range(15));
    it.exclude_mask = EXCL_W'($urandom());

    used = $countones(tbl_valid);
    roll = $urandom_range(99);
    if (roll < 4)
      it.operation = ica_pkg::OP_NOP;
    else if (used > fill_target)
      it.operation = (roll < 50) ? ica_pkg::OP_REMOVE :
                     (roll < 62) ? ica_pkg::OP_APPEND : ica_pkg::OP_VALIDATE;
    else
      it.operation = (roll < 44) ? ica_pkg::OP_APPEND :
                     (roll < 54) ? ica_pkg::OP_REMOVE : ica_pkg::OP_VALIDATE;

    if (it.operation == ica_pkg::OP_VALIDATE) begin
      case ($urandom_range(3))
        0:       ;  // keep the full random mask
        1:       it.exclude_mask = EXCL_W'(1) << $urandom_range(EXCL_W - 1);
        default: it.exclude_mask = '0;
      endcase
    end
    if (it.operation == ica_pkg::OP_REMOVE && $urandom_range(99) < 85) begin
      for (int i = 0; i < TABLE_SLOTS; i++)
        if (tbl_valid[i]) live.insert(live.size(), i);
      if (live.size() != 0)
        it.remove_slot = RSLOT_W'(live[$urandom_range(live.size() - 1)]);
    end
    return it;
  endfunction

  task automatic run_random_items(input int count, input int fill_target);
    for (int n = 0; n < count; n++)
      send_request(pick_request(fill_target));
  endtask

  // --------------------------------------------------------------------------
  // Result side: check each item taken, then choose the next ready
  // --------------------------------------------------------------------------
  initial begin : result_side
    alloc_result_t want;
    rsp.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        results_seen++;
        if (rsp.status < 5) status_seen[rsp.status]++;
        if (alloc_expect_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= SHOW_LIMIT)
            $display("unexpected result at cycle %0d: status=%0d ch=%0d slot=%0d empty=%0d",
                     cycle_count, rsp.status, rsp.assigned_channel, rsp.slot,
                     rsp.table_empty);
        end else begin
          want = alloc_expect_q.pop_front();
          if (rsp.status !== want.status ||
              rsp.assigned_channel !== want.assigned_channel ||
              rsp.slot !== want.slot || rsp.table_empty !== want.table_empty) begin
            mismatch_count++;
            if (mismatch_count <= SHOW_LIMIT) begin
              $display("mismatch on result %0d:", results_seen);
              $display("  expected status=%0d ch=%0d slot=%0d empty=%0d",
                       want.status, want.assigned_channel, want.slot,
                       want.table_empty);
              $display("  got      status=%0d ch=%0d slot=%0d empty=%0d",
                       rsp.status, rsp.assigned_channel, rsp.slot,
                       rsp.table_empty);
            end
          end
        end
      end
      // Pick up a hold-off request, then count it down with ready held low.
      if (hold_request != 0) begin
        holdoff_left = hold_request;
        hold_request = 0;
      end
      if (rst) begin
        rsp.ready <= 1'b0;
      end else if (holdoff_left != 0) begin
        holdoff_left--;
        rsp.ready <= 1'b0;
      end else if (!steady_flow && $urandom_range(99) < IDLE_PCT) begin
        rsp.ready <= 1'b0;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Empty table right after reset: a validate finds channel 1, remove
  // reports an empty slot, the no-op only reports the fill.
  task automatic test_empty_table();
    alloc_req_t it;
    send_request(mk_validate('0, '1, '0));
    send_request(mk_remove(RSLOT_W'(5)));
    it           = '0;
    it.operation = ica_pkg::OP_NOP;
    send_request(it);
  endtask

  // Overlap rules and channel choice: touching endpoints, reversed segment,
  // excluded slots, no free real channel, data channels used up, extremes.
  task automatic test_channel_choice();
    send_request(mk_append(32'd100, 32'd200, 4'd0,  3'd1));
    send_request(mk_append(32'd150, 32'd250, 4'd15, 3'd2));
    send_request(mk_append(32'd50,  32'd100, 4'd0,  3'd3));   // touches at 100
    send_request(mk_append(32'd200, 32'd200, 4'd15, 3'd4));   // single tick
    send_request(mk_append('0,      '1,      4'd0,  3'd5));   // whole time range
    send_request(mk_append(32'd300, 32'd120, 4'd15, 3'd6));   // end before start
    // channels 1..6 all held by two data channels: no free real channel
    send_request(mk_validate(32'd100, 32'd200, '0));
    // drop slot 2 through the mask: its channel 3 comes free
    send_request(mk_validate(32'd100, 32'd200, 16'h0004));
    send_request(mk_validate(32'd201, 32'd201, '0));
    send_request(mk_append(32'd120, 32'd180, 4'd3, 3'd0));
    send_request(mk_append('1,      '1,      4'd4, 3'd7));
    send_request(mk_append(32'd110, 32'd110, 4'd5, 3'd7));
    send_request(mk_append(32'd199, 32'd400, 4'd6, 3'd0));
    send_request(mk_append(32'd180, 32'd190, 4'd9, 3'd1));
    // six distinct data channels overlap now: exhausted
    send_request(mk_validate(32'd100, 32'd200, '0));
    send_request(mk_validate('1, '1, '0));
    send_request(mk_validate(32'd100, 32'd200, '1));
  endtask

  // Fill the remaining slots, overflow, then free one slot twice and reuse it.
  task automatic test_table_full();
    while (tbl_valid != '1)
      send_request(mk_append(pick_tick(), pick_tick(), DCH_W'($urandom_range(15)),
                             CH_W'($urandom_range(7))));
    send_request(mk_append(32'd10, 32'd20, 4'd1, 3'd1));      // table full
    send_request(mk_remove(RSLOT_W'(3)));
    send_request(mk_remove(RSLOT_W'(3)));                     // already free
    send_request(mk_append(32'd5, 32'd6, 4'd2, 3'd2));        // reuses slot 3
  endtask

  // Random traffic through low, middle, high and full table fill.
  task automatic test_random_mix();
    run_random_items(180, 3);
    run_random_items(180, 9);
    run_random_items(180, 14);
    run_random_items(180, TABLE_SLOTS);
  endtask

  // No idle cycles on either side: back-to-back items on every phase.
  task automatic test_no_idle_stretch();
    steady_flow = 1'b1;
    run_random_items(150, 10);
    steady_flow = 1'b0;
  endtask

  // Hold results off for a long stretch while requests keep coming, so the
  // block fills and stalls the request channel.
  task automatic test_result_backpressure();
    hold_request = 400;
    run_random_items(60, 8);
  endtask

  // Pause requests until every pending result is back, then resume.
  task automatic test_drain_pause();
    run_random_items(100, 6);
    req.valid <= 1'b0;
    while (alloc_expect_q.size() != 0) @(posedge clk);
    run_random_items(100, 12);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    rst              <= 1'b1;
    req.valid        <= 1'b0;
    req.operation    <= ica_pkg::OP_NOP;
    req.start_time   <= '0;
    req.end_time     <= '0;
    req.data_channel <= '0;
    req.channel      <= '0;
    req.remove_slot  <= '0;
    req.exclude_mask <= '0;
    tbl_valid        = '0;
    steady_flow      = 1'b0;
    hold_request     = 0;
    holdoff_left     = 0;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_empty_table();
    test_channel_choice();
    test_table_full();
    test_random_mix();
    test_no_idle_stretch();
    test_result_backpressure();
    test_drain_pause();

    // Drop valid, wait for the last results, then allow a quiet tail in case
    // anything stray comes out.
    req.valid <= 1'b0;
    while (alloc_expect_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (alloc_expect_q.size() != 0) begin
      mismatch_count += alloc_expect_q.size();
      $display("%0d results never arrived", alloc_expect_q.size());
    end

    $display("Run covered %0d requests: %0d validate, %0d append, %0d remove, %0d no-op",
             op_seen[0] + op_seen[1] + op_seen[2] + op_seen[3],
             op_seen[ica_pkg::OP_VALIDATE], op_seen[ica_pkg::OP_APPEND],
             op_seen[ica_pkg::OP_REMOVE], op_seen[ica_pkg::OP_NOP]);
    $display("Results checked: %0d (ok %0d, data exhausted %0d, no channel %0d,",
             results_seen, status_seen[ica_pkg::ST_OK],
             status_seen[ica_pkg::ST_DATA_EXHAUSTED], status_seen[ica_pkg::ST_NO_CHANNEL]);
    $display("  full %0d, slot empty %0d), %0d mismatches",
             status_seen[ica_pkg::ST_FULL], status_seen[ica_pkg::ST_SLOT_EMPTY],
             mismatch_count);

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
